### src/obsesc_pkg.sv
// Package with state, command and register codes of the obstacle escape sequencer.
package obsesc_pkg;

	localparam int StateW = 3;
	localparam logic [StateW-1:0] ST_IDLE    = 3'd0;
	localparam logic [StateW-1:0] ST_MONITOR = 3'd1;
	localparam logic [StateW-1:0] ST_PAUSE   = 3'd2;
	localparam logic [StateW-1:0] ST_REVERSE = 3'd3;
	localparam logic [StateW-1:0] ST_TURN    = 3'd4;
	localparam logic [StateW-1:0] ST_WAIT    = 3'd5;
	localparam logic [StateW-1:0] ST_RESUME  = 3'd6;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_MOVE = 2'd1;
	localparam logic [1:0] KIND_STOP = 2'd2;

	localparam logic [1:0] OBS_CLEAR   = 2'd0;
	localparam logic [1:0] OBS_BLOCKED = 2'd1;

	localparam logic [2:0] MODE_STOPPED = 3'd0;
	localparam logic [2:0] MODE_REVERSE = 3'd2;
	localparam logic [2:0] MODE_RIGHT   = 3'd4;

	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;
	localparam logic [CfgIdxW-1:0] REG_ENABLE   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_PAUSE    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_REVERSE  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_TURN     = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_TIMEOUT  = 3'd4;

	localparam logic [15:0] PAUSE_RST   = 16'd200;
	localparam logic [15:0] REVERSE_RST = 16'd600;
	localparam logic [15:0] TURN_RST    = 16'd400;
	localparam logic [15:0] TIMEOUT_RST = 16'd3000;

endpackage

### src/obstacle_escape_sequencer_core.sv
// Top level of the obstacle escape sequencer: input stage, state update and result register.
//
// The block takes one update tick per item and returns exactly one result item per tick.
// An accepted tick lands in an input register; once the result register can take it, one
// pass of logic (a 32-bit wrapping subtraction of the phase start from now_ms and a compare
// against the selected 16-bit duration) updates the sequencer state and loads the result
// register. A new tick can be taken in every cycle while the result side does not stall;
// the rate is one item per cycle, limited only by the single state register
// that each tick reads and writes. When the result register is stalled, the input stage
// holds one more tick and then stalls the input side. While enabled, the sequence runs
// from monitoring through a pause after a blocked status, a reverse move, a right turn and
// a stop, and then waits for clearance; on clearance it resumes the remembered command if
// there is one, on timeout it raises clear_saved and returns to monitoring. Writing 0 to
// the enable register, or a tick taken while it is 0, returns the block to idle. Users must
// write configuration via cfg_we, cfg_index and cfg_data with no tick in flight; unenforced.
module obstacle_escape_sequencer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [obsesc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [obsesc_pkg::CfgDataW-1:0] cfg_data,
	// tick input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [31:0]                    now_ms,
	input  logic [1:0]                     obstacle_state,
	input  logic                           saved_valid,
	input  logic [2:0]                     saved_mode,
	input  logic [15:0]                    saved_duration_ms,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           cmd_valid,
	output logic [1:0]                     cmd_kind,
	output logic [2:0]                     drive_mode,
	output logic [15:0]                    duration_ms,
	output logic                           clear_saved
);
	import obsesc_pkg::*;

	// Configuration registers.
	logic        enable_q;
	logic [15:0] pause_q;
	logic [15:0] reverse_q;
	logic [15:0] turn_q;
	logic [15:0] timeout_q;

	// Sequencer state.
	logic [StateW-1:0] state_q;
	logic [31:0]       phase_q;

	// Input stage.
	logic        valid_s1;
	logic [31:0] now_s1;
	logic [1:0]  obs_s1;
	logic        sv_valid_s1;
	logic [2:0]  sv_mode_s1;
	logic [15:0] sv_dur_s1;

	// Result register.
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [2:0]  mode_q;
	logic [15:0] dur_q;
	logic        clr_q;

	// The tick in the input stage moves on when the result register is free or drains now.
	logic advance;
	logic in_take;
	assign advance  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Next-state logic for the tick held in the input stage.
	logic [StateW-1:0] nxt_state;
	logic [31:0]       nxt_phase;
	logic [31:0]       elapsed;
	logic [StateW-1:0] eff_state;
	logic [1:0]        kind_c;
	logic [2:0]        mode_c;
	logic [15:0]       dur_c;
	logic              clr_c;

	assign elapsed   = now_s1 - phase_q;
	// Leaving idle goes straight to monitoring and is evaluated in the same tick.
	assign eff_state = (state_q == ST_IDLE) ? ST_MONITOR : state_q;

	always_comb begin
		nxt_state = state_q;
		nxt_phase = phase_q;
		kind_c    = KIND_NONE;
		mode_c    = MODE_STOPPED;
		dur_c     = 16'd0;
		clr_c     = 1'b0;
		if (!enable_q) begin
			nxt_state = ST_IDLE;
		end else begin
			nxt_state = eff_state;
			case (eff_state)
				ST_MONITOR: begin
					if (obs_s1 == OBS_BLOCKED) begin
						nxt_state = ST_PAUSE;
						nxt_phase = now_s1;
					end
				end
				ST_PAUSE: begin
					// The pause test is strictly greater; the others are at-or-above.
					if (elapsed > {16'd0, pause_q}) begin
						kind_c    = KIND_MOVE;
						mode_c    = MODE_REVERSE;
						dur_c     = reverse_q;
						nxt_phase = now_s1;
						nxt_state = ST_REVERSE;
					end
				end
				ST_REVERSE: begin
					if (elapsed >= {16'd0, reverse_q}) begin
						kind_c    = KIND_MOVE;
						mode_c    = MODE_RIGHT;
						dur_c     = turn_q;
						nxt_phase = now_s1;
						nxt_state = ST_TURN;
					end
				end
				ST_TURN: begin
					if (elapsed >= {16'd0, turn_q}) begin
						kind_c    = KIND_STOP;
						nxt_phase = now_s1;
						nxt_state = ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (obs_s1 == OBS_CLEAR) begin
						nxt_state = ST_RESUME;
					end else if (elapsed >= {16'd0, timeout_q}) begin
						clr_c     = 1'b1;
						nxt_state = ST_MONITOR;
					end
				end
				ST_RESUME: begin
					// Nothing remembered means no command, but monitoring resumes anyway.
					if (sv_valid_s1 && (sv_mode_s1 != MODE_STOPPED)) begin
						kind_c = KIND_MOVE;
						mode_c = sv_mode_s1;
						dur_c  = sv_dur_s1;
					end
					nxt_state = ST_MONITOR;
				end
				default: begin
					nxt_state = ST_MONITOR;
				end
			endcase
		end
	end

	// Configuration registers; clearing the enable forces the sequencer to idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			pause_q   <= PAUSE_RST;
			reverse_q <= REVERSE_RST;
			turn_q    <= TURN_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:  enable_q  <= cfg_data[0];
				REG_PAUSE:   pause_q   <= cfg_data;
				REG_REVERSE: reverse_q <= cfg_data;
				REG_TURN:    turn_q    <= cfg_data;
				REG_TIMEOUT: timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 32'd0;
		end else if (cfg_we && (cfg_index == REG_ENABLE) && !cfg_data[0]) begin
			state_q <= ST_IDLE;
		end else if (advance) begin
			state_q <= nxt_state;
			phase_q <= nxt_phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			now_s1      <= now_ms;
			obs_s1      <= obstacle_state;
			sv_valid_s1 <= saved_valid;
			sv_mode_s1  <= saved_mode;
			sv_dur_s1   <= saved_duration_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q <= kind_c;
			mode_q <= mode_c;
			dur_q  <= dur_c;
			clr_q  <= clr_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign cmd_valid   = (kind_q != KIND_NONE);
	assign cmd_kind    = kind_q;
	assign drive_mode  = mode_q;
	assign duration_ms = dur_q;
	assign clear_saved = clr_q;

	// The sequencer only leaves idle while enabled.
	a_idle_when_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> enable_q)
		else $error("sequencer active while disabled");

	// A clearance timeout returns the sequencer to monitoring when no configuration write comes with it.
	a_timeout_to_monitor: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && clr_c && !cfg_we) |=> (state_q == ST_MONITOR))
		else $error("timeout did not return to monitoring");

	// A tick held back by a stalled result stays in the input stage unchanged.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(now_s1) && $stable(obs_s1)))
		else $error("input stage lost a held tick");

	// Input is stalled only while a tick waits in the input stage.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without cause");

	// A stop or empty result never carries a drive mode or duration.
	a_stop_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (kind_q != KIND_MOVE)) |-> ((mode_q == MODE_STOPPED) && (dur_q == 16'd0)))
		else $error("non-move result carries move fields");

endmodule

### verif/escape_check_pkg.sv
// Result prediction and checking for the obstacle escape sequencer testbench.
`timescale 1ns / 100ps

package escape_check_pkg;

	import obsesc_pkg::*;

	typedef struct packed {
		logic        cmd_valid;
		logic [1:0]  kind;
		logic [2:0]  mode;
		logic [15:0] dur;
		logic        clr;
	} escape_cmd_t;

	class escape_scoreboard;
		logic              enable;
		logic [15:0]       pause_ms;
		logic [15:0]       reverse_ms;
		logic [15:0]       turn_ms;
		logic [15:0]       timeout_ms;
		logic [StateW-1:0] seq;
		logic [31:0]       phase_start;
		escape_cmd_t       expected_cmds[$];
		int                errors;

		function new();
			enable      = 1'b0;
			pause_ms    = PAUSE_RST;
			reverse_ms  = REVERSE_RST;
			turn_ms     = TURN_RST;
			timeout_ms  = TIMEOUT_RST;
			seq         = ST_IDLE;
			phase_start = '0;
			errors      = 0;
		endfunction

		function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
			case (idx)
				REG_ENABLE: begin
					enable = data[0];
					if (!enable)
						seq = ST_IDLE;
				end
				REG_PAUSE:   pause_ms = data;
				REG_REVERSE: reverse_ms = data;
				REG_TURN:    turn_ms = data;
				REG_TIMEOUT: timeout_ms = data;
				default: ;
			endcase
		endfunction

		// Advances the sequencer copy by one tick and queues the command it issues.
		function void note_tick(logic [31:0] now, logic [1:0] obs, logic sv,
				logic [2:0] smode, logic [15:0] sdur);
			escape_cmd_t res;
			logic [31:0] elapsed;
			res = '0;
			if (!enable) begin
				seq = ST_IDLE;
			end else begin
				if (seq == ST_IDLE)
					seq = ST_MONITOR;
				elapsed = now - phase_start;
				case (seq)
					ST_MONITOR: begin
						if (obs == OBS_BLOCKED) begin
							seq = ST_PAUSE;
							phase_start = now;
						end
					end
					ST_PAUSE: begin
						if (elapsed > {16'd0, pause_ms}) begin
							res.kind = KIND_MOVE;
							res.mode = MODE_REVERSE;
							res.dur = reverse_ms;
							phase_start = now;
							seq = ST_REVERSE;
						end
					end
					ST_REVERSE: begin
						if (elapsed >= {16'd0, reverse_ms}) begin
							res.kind = KIND_MOVE;
							res.mode = MODE_RIGHT;
							res.dur = turn_ms;
							phase_start = now;
							seq = ST_TURN;
						end
					end
					ST_TURN: begin
						if (elapsed >= {16'd0, turn_ms}) begin
							res.kind = KIND_STOP;
							phase_start = now;
							seq = ST_WAIT;
						end
					end
					ST_WAIT: begin
						if (obs == OBS_CLEAR) begin
							seq = ST_RESUME;
						end else if (elapsed >= {16'd0, timeout_ms}) begin
							res.clr = 1'b1;
							seq = ST_MONITOR;
						end
					end
					ST_RESUME: begin
						if (sv && smode != MODE_STOPPED) begin
							res.kind = KIND_MOVE;
							res.mode = smode;
							res.dur = sdur;
						end
						seq = ST_MONITOR;
					end
					default: seq = ST_MONITOR;
				endcase
			end
			res.cmd_valid = (res.kind != KIND_NONE);
			expected_cmds.push_back(res);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(escape_cmd_t got);
			escape_cmd_t want;
			if (expected_cmds.size() == 0) begin
				$error("result with no tick pending: kind %0d mode %0d", got.kind, got.mode);
				errors++;
				return;
			end
			want = expected_cmds.pop_front();
			compare_field("cmd_valid", want.cmd_valid, got.cmd_valid);
			compare_field("cmd_kind", want.kind, got.kind);
			compare_field("drive_mode", want.mode, got.mode);
			compare_field("duration_ms", want.dur, got.dur);
			compare_field("clear_saved", want.clr, got.clr);
		endfunction
	endclass

endpackage

### verif/testbench.sv
// Top-level testbench of the obstacle escape sequencer core.
`timescale 1ns / 100ps

module testbench;

	import obsesc_pkg::*;
	import escape_check_pkg::*;

	// Obstacle codes that mean neither blocked nor clear.
	localparam logic [1:0] OBS_CAUTION = 2'd2;
	localparam logic [1:0] OBS_OTHER   = 2'd3;

	localparam int NumPhases   = 14;
	localparam int QuietPhase  = 12;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                in_valid;
	logic                in_stall;
	logic [31:0]         now_ms;
	logic [1:0]          obstacle_state;
	logic                saved_valid;
	logic [2:0]          saved_mode;
	logic [15:0]         saved_duration_ms;
	logic                out_valid;
	logic                out_stall;
	logic                cmd_valid;
	logic [1:0]          cmd_kind;
	logic [2:0]          drive_mode;
	logic [15:0]         duration_ms;
	logic                clear_saved;

	escape_scoreboard sb;
	// Last timestamp sent; random timestamps mostly walk forward from it.
	logic [31:0] clock_ms;
	// Set for the final stretch of the run, where neither side idles.
	logic        quiet;

	obstacle_escape_sequencer_core i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.now_ms           (now_ms),
		.obstacle_state   (obstacle_state),
		.saved_valid      (saved_valid),
		.saved_mode       (saved_mode),
		.saved_duration_ms(saved_duration_ms),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.cmd_valid        (cmd_valid),
		.cmd_kind         (cmd_kind),
		.drive_mode       (drive_mode),
		.duration_ms      (duration_ms),
		.clear_saved      (clear_saved)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Safety net: a hang anywhere ends the run as a failure.
	initial begin
		#5_000_000;
		$display("obstacle_escape_sequencer_core: mismatch");
		$finish;
	end

	// The result side stalls in random bursts, with runs of free flow in
	// between. Stalls change on the falling edge only.
	initial begin : result_sink
		int hold;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0 && !quiet && $urandom_range(0, 5) == 0)
				hold = $urandom_range(1, 7);
			out_stall = (hold != 0);
			if (hold != 0)
				hold--;
		end
	end

	// Both channels are observed at the rising edge. The result is checked
	// before the tick of the same edge is noted, since a tick accepted at this
	// edge cannot have produced a result yet.
	always @(posedge clk) begin : observe
		escape_cmd_t seen;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen.cmd_valid = cmd_valid;
				seen.kind = cmd_kind;
				seen.mode = drive_mode;
				seen.dur = duration_ms;
				seen.clr = clear_saved;
				sb.check_result(seen);
			end
			if (in_valid && !in_stall)
				sb.note_tick(now_ms, obstacle_state, saved_valid, saved_mode,
					saved_duration_ms);
		end
	end

	// Register writes happen only while no tick is in flight, so the predictor
	// copy is updated at once.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Offers one tick and holds it until the block takes it. Returns on the
	// falling edge after acceptance with valid still high, so back-to-back
	// ticks flow without a bubble unless a random gap is drawn.
	task automatic send_tick(input logic [31:0] now, input logic [1:0] obs, input logic sv,
			input logic [2:0] smode, input logic [15:0] sdur);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		now_ms = now;
		obstacle_state = obs;
		saved_valid = sv;
		saved_mode = smode;
		saved_duration_ms = sdur;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// Stops sending and waits until every expected result has come back, then
	// lets the input stage and result register settle before anything else happens.
	task automatic wait_drained();
		in_valid = 1'b0;
		while (sb.expected_cmds.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Timestamps aim at the edge of the running phase's time test (one below,
	// at, and one above it) much of the time, so the sequence actually moves
	// through its phases; the rest are small and large steps and raw jumps.
	function automatic logic [31:0] pick_now();
		logic [31:0] mark;
		int unsigned roll;
		case (sb.seq)
			ST_PAUSE:   mark = {16'd0, sb.pause_ms} + 32'd1;
			ST_REVERSE: mark = {16'd0, sb.reverse_ms};
			ST_TURN:    mark = {16'd0, sb.turn_ms};
			ST_WAIT:    mark = {16'd0, sb.timeout_ms};
			default:    mark = 32'd0;
		endcase
		roll = $urandom_range(0, 9);
		if (roll < 4 && sb.enable && sb.seq >= ST_PAUSE && sb.seq <= ST_WAIT)
			return sb.phase_start + mark + 32'($urandom_range(0, 2)) - 32'd1;
		if (roll < 7)
			return clock_ms + 32'($urandom_range(0, 3));
		if (roll < 9)
			return clock_ms + 32'($urandom_range(0, 2 * mark + 4));
		return $urandom();
	endfunction

	// Obstacle status is biased toward whatever moves the current phase on,
	// with the two caution codes mixed in.
	function automatic logic [1:0] pick_obstacle();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		case (sb.seq)
			ST_IDLE, ST_MONITOR: begin
				if (roll < 6) return OBS_BLOCKED;
				if (roll < 8) return OBS_CLEAR;
			end
			ST_WAIT: begin
				if (roll < 4) return OBS_CLEAR;
				if (roll < 7) return OBS_BLOCKED;
			end
			default: return 2'($urandom_range(0, 3));
		endcase
		return (roll[0]) ? OBS_OTHER : OBS_CAUTION;
	endfunction

	task automatic send_random();
		logic [31:0] now;
		logic [15:0] sdur;
		now = pick_now();
		clock_ms = now;
		case ($urandom_range(0, 7))
			0:       sdur = '0;
			1:       sdur = '1;
			default: sdur = 16'($urandom());
		endcase
		send_tick(now, pick_obstacle(), $urandom_range(0, 3) != 0,
			3'($urandom_range(0, 7)), sdur);
	endtask

	// Durations are mostly tiny so that full escape sequences happen often;
	// now and then one is drawn from the whole 16-bit range.
	function automatic logic [15:0] pick_ms();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, 40));
	endfunction

	// One configuration per phase: all-zero durations, all-ones durations,
	// a disabled stretch, then random settings. Enable is sometimes left as
	// it is so the sequence carries across a phase boundary, and sometimes
	// dropped and raised again, which forces idle.
	task automatic set_phase(input int phase);
		case (phase)
			0: begin
				write_reg(REG_ENABLE, 16'd1);
				write_reg(REG_PAUSE, '0);
				write_reg(REG_REVERSE, '0);
				write_reg(REG_TURN, '0);
				write_reg(REG_TIMEOUT, '0);
			end
			1: begin
				write_reg(REG_PAUSE, '1);
				write_reg(REG_REVERSE, '1);
				write_reg(REG_TURN, '1);
				write_reg(REG_TIMEOUT, '1);
			end
			2: write_reg(REG_ENABLE, 16'd0);
			default: begin
				if ($urandom_range(0, 3) == 0)
					write_reg(REG_ENABLE, 16'd0);
				if (!sb.enable || $urandom_range(0, 1) == 0)
					write_reg(REG_ENABLE, 16'd1);
				write_reg(REG_PAUSE, pick_ms());
				write_reg(REG_REVERSE, pick_ms());
				write_reg(REG_TURN, pick_ms());
				write_reg(REG_TIMEOUT, pick_ms());
			end
		endcase
		// Indexes above the last register must leave everything unchanged.
		write_reg(REG_TIMEOUT + CfgIdxW'($urandom_range(1, 3)), 16'($urandom()));
	endtask

	// Directed ticks: disabled ticks first, then a short configuration under
	// which the timestamps walk across the 32-bit wrap, hit every time test
	// exactly at its limit (all but the turn test also next to it), and end
	// once in resume with a pass-through mode, once in a timeout and once in
	// resume with nothing to resume.
	task automatic run_directed();
		send_tick(32'hFFFF_FFFF, OBS_BLOCKED, 1'b1, 3'd7, 16'hFFFF);
		send_tick(32'h0000_0000, OBS_CLEAR, 1'b0, MODE_STOPPED, 16'h0000);
		wait_drained();
		write_reg(REG_PAUSE, 16'd2);
		write_reg(REG_REVERSE, 16'd3);
		write_reg(REG_TURN, 16'd1);
		write_reg(REG_TIMEOUT, 16'd5);
		write_reg(REG_ENABLE, 16'd1);
		send_tick(32'hFFFF_FFFD, OBS_CAUTION, 1'b0, MODE_STOPPED, 16'd0);
		send_tick(32'hFFFF_FFFE, OBS_OTHER, 1'b0, MODE_STOPPED, 16'd0);
		send_tick(32'hFFFF_FFFF, OBS_BLOCKED, 1'b0, MODE_STOPPED, 16'd0);
		// Pause: elapsed equal to the limit waits, one more reverses.
		send_tick(32'd1, OBS_BLOCKED, 1'b0, MODE_STOPPED, 16'd0);
		send_tick(32'd2, OBS_BLOCKED, 1'b0, MODE_STOPPED, 16'd0);
		send_tick(32'd4, OBS_BLOCKED, 1'b0, MODE_STOPPED, 16'd0);
		send_tick(32'd5, OBS_BLOCKED, 1'b0, MODE_STOPPED, 16'd0);
		send_tick(32'd6, OBS_BLOCKED, 1'b0, MODE_STOPPED, 16'd0);
		send_tick(32'd7, OBS_OTHER, 1'b0, MODE_STOPPED, 16'd0);
		send_tick(32'd8, OBS_CLEAR, 1'b0, MODE_STOPPED, 16'd0);
		// Resume with a mode outside the named ones: it passes through as is.
		send_tick(32'd9, OBS_BLOCKED, 1'b1, 3'd7, 16'hFFFF);
		send_tick(32'd10, OBS_BLOCKED, 1'b0, MODE_STOPPED, 16'd0);
		send_tick(32'd13, OBS_BLOCKED, 1'b0, MODE_STOPPED, 16'd0);
		send_tick(32'd16, OBS_BLOCKED, 1'b0, MODE_STOPPED, 16'd0);
		send_tick(32'd17, OBS_BLOCKED, 1'b0, MODE_STOPPED, 16'd0);
		// Waiting for clearance: one short of the timeout, then the timeout.
		send_tick(32'd21, OBS_BLOCKED, 1'b0, MODE_STOPPED, 16'd0);
		send_tick(32'd22, OBS_CAUTION, 1'b0, MODE_STOPPED, 16'd0);
		send_tick(32'd23, OBS_BLOCKED, 1'b0, MODE_STOPPED, 16'd0);
		send_tick(32'd26, OBS_BLOCKED, 1'b0, MODE_STOPPED, 16'd0);
		send_tick(32'd29, OBS_BLOCKED, 1'b0, MODE_STOPPED, 16'd0);
		send_tick(32'd30, OBS_BLOCKED, 1'b0, MODE_STOPPED, 16'd0);
		send_tick(32'd31, OBS_CLEAR, 1'b0, MODE_STOPPED, 16'd0);
		// A valid saved command whose mode is stopped issues nothing.
		send_tick(32'd32, OBS_BLOCKED, 1'b1, MODE_STOPPED, 16'd1234);
		clock_ms = 32'd32;
	endtask

	initial begin
		sb = new();
		quiet = 1'b0;
		clock_ms = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_data = '0;
		in_valid = 1'b0;
		now_ms = '0;
		obstacle_state = OBS_CLEAR;
		saved_valid = 1'b0;
		saved_mode = MODE_STOPPED;
		saved_duration_ms = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();

		// Random phases. Each one drains before its registers change, and the
		// sender also holds off once in the middle of each phase until every
		// expected result has come back.
		for (int phase = 0; phase < NumPhases; phase++) begin
			int n_ticks;
			wait_drained();
			quiet = (phase >= QuietPhase);
			set_phase(phase);
			n_ticks = (phase == 2) ? 30 : 130;
			for (int i = 0; i < n_ticks; i++) begin
				if (i == n_ticks / 2)
					wait_drained();
				send_random();
			end
		end

		wait_drained();
		if (sb.errors == 0 && sb.expected_cmds.size() == 0) begin
			$display("obstacle_escape_sequencer_core: match");
		end else begin
			$display("obstacle_escape_sequencer_core: mismatch");
		end
		$finish;
	end

endmodule
